// ----- sv/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared types and character constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_CR,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        OUT_BUSY     = 2'd0,
        OUT_COMPLETE = 2'd1,
        OUT_PROTO    = 2'd2,
        OUT_OVERFLOW = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       is_last;
    } body_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        outcome_t   outcome;
    } result_item_t;

endpackage

// ----- sv/http_chunked_body_decoder_unit.sv -----
// An accepted body byte passes through the input register, then the result register.
// Throughput: one byte per cycle unless result_ready stalls the result register.
// The input register and the result register each hold one transaction.
// Reset: rst_n low clears both registers and returns the parser to the start of
// a size line with the outcome in progress.
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Parses chunk size lines and CRLF framing one byte at a time, passes
// payload bytes through and reports a sticky outcome per body.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 body_valid,
    output logic                 body_ready,
    input  hcbd_pkg::body_item_t body,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hcbd_pkg::result_item_t result
);
    import hcbd_pkg::*;

    // Input stage
    logic          s1_valid_reg;
    body_item_t    s1_item_reg;

    // Result stage
    logic          result_valid_reg;
    result_item_t  result_item_reg;
    result_item_t  result_item_next;

    // Parser state
    phase_t                 phase_reg, phase_next, phase_step;
    logic [SIZE_BITS-1:0]   chunk_left_reg, chunk_left_next, chunk_step;
    logic                   digits_closed_reg, digits_closed_next, closed_step;
    logic                   digit_seen_reg, digit_seen_next, seen_step;
    logic                   size_too_big_reg, size_too_big_next, big_step;
    outcome_t               final_outcome_reg, final_outcome_next, fo_step;

    logic       result_free;
    logic       advance;
    logic [7:0] b;
    logic       last;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] hex_diff;
    logic       text_en;
    logic       size_eol;

    assign result_free = !result_valid_reg || result_ready;
    assign advance     = s1_valid_reg && result_free;
    assign body_ready  = !s1_valid_reg || result_free;

    assign b    = s1_item_reg.body_byte;
    assign last = s1_item_reg.is_last;

    always_comb
    begin
        hex_ok   = 1'b1;
        hex_diff = b - 8'h30;
        if (b inside {[8'h30:8'h39]})
        begin
            hex_diff = b - 8'h30;
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            hex_diff = b - 8'h57;
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            hex_diff = b - 8'h37;
        end
        else
        begin
            hex_ok = 1'b0;
        end
        hex_val = hex_diff[3:0];
    end

    // Next state of the parser for the byte in the input stage.
    always_comb
    begin
        phase_step  = phase_reg;
        chunk_step  = chunk_left_reg;
        closed_step = digits_closed_reg;
        seen_step   = digit_seen_reg;
        big_step    = size_too_big_reg;
        fo_step     = final_outcome_reg;
        text_en     = 1'b0;
        size_eol    = 1'b0;

        case (phase_reg)
            PH_SIZE, PH_SIZE_CR:
            begin
                if (b == CHAR_NUL)
                begin
                    phase_step = PH_DONE;
                    fo_step    = OUT_PROTO;
                end
                else if (b == CHAR_CR)
                begin
                    // Only the first CR of a run counts as line text.
                    text_en    = (phase_reg == PH_SIZE);
                    phase_step = PH_SIZE_CR;
                end
                else if (b == CHAR_LF && phase_reg == PH_SIZE_CR)
                begin
                    size_eol = 1'b1;
                end
                else
                begin
                    text_en    = 1'b1;
                    phase_step = PH_SIZE;
                end
            end
            PH_DATA:
            begin
                chunk_step = chunk_left_reg - SIZE_BITS'(1);
                if (chunk_step == '0)
                begin
                    phase_step = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
            begin
                if (b == CHAR_CR)
                begin
                    phase_step = PH_DATA_LF;
                end
                else
                begin
                    phase_step = PH_DONE;
                    fo_step    = OUT_PROTO;
                end
            end
            PH_DATA_LF:
            begin
                if (b == CHAR_LF)
                begin
                    phase_step  = PH_SIZE;
                    chunk_step  = '0;
                    closed_step = 1'b0;
                    seen_step   = 1'b0;
                    big_step    = 1'b0;
                end
                else
                begin
                    phase_step = PH_DONE;
                    fo_step    = OUT_PROTO;
                end
            end
            default:
            begin
            end
        endcase

        if (text_en && !digits_closed_reg)
        begin
            if (hex_ok)
            begin
                seen_step = 1'b1;
                if (!size_too_big_reg)
                begin
                    // Shifting in another digit overflows if the top nibble is busy.
                    if (chunk_left_reg[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        big_step = 1'b1;
                    end
                    else
                    begin
                        chunk_step = {chunk_left_reg[SIZE_BITS-5:0], hex_val};
                    end
                end
            end
            else if (!(!digit_seen_reg && (b == CHAR_SPACE || b == CHAR_TAB)))
            begin
                closed_step = 1'b1;
            end
        end

        if (size_eol)
        begin
            if (size_too_big_reg)
            begin
                phase_step = PH_DONE;
                fo_step    = OUT_OVERFLOW;
            end
            else if (chunk_left_reg == '0)
            begin
                phase_step = PH_DONE;
                fo_step    = OUT_COMPLETE;
            end
            else
            begin
                phase_step = PH_DATA;
            end
        end

        if (last)
        begin
            phase_next         = PH_SIZE;
            chunk_left_next    = '0;
            digits_closed_next = 1'b0;
            digit_seen_next    = 1'b0;
            size_too_big_next  = 1'b0;
            final_outcome_next = OUT_BUSY;
        end
        else
        begin
            phase_next         = phase_step;
            chunk_left_next    = chunk_step;
            digits_closed_next = closed_step;
            digit_seen_next    = seen_step;
            size_too_big_next  = big_step;
            final_outcome_next = fo_step;
        end
    end

    // Result for the byte in the input stage.
    always_comb
    begin
        result_item_next.data_valid = (phase_reg == PH_DATA);
        result_item_next.data_byte  = (phase_reg == PH_DATA) ? b : 8'd0;
        if (last && fo_step == OUT_BUSY)
        begin
            // A body that ends while payload is still owed counts as overflow.
            result_item_next.outcome = (phase_step == PH_DATA) ? OUT_OVERFLOW : OUT_PROTO;
        end
        else
        begin
            result_item_next.outcome = fo_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            phase_reg         <= PH_SIZE;
            chunk_left_reg    <= '0;
            digits_closed_reg <= 1'b0;
            digit_seen_reg    <= 1'b0;
            size_too_big_reg  <= 1'b0;
            final_outcome_reg <= OUT_BUSY;
        end
        else
        begin
            if (body_ready)
            begin
                s1_valid_reg <= body_valid;
            end
            if (result_free)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                phase_reg         <= phase_next;
                chunk_left_reg    <= chunk_left_next;
                digits_closed_reg <= digits_closed_next;
                digit_seen_reg    <= digit_seen_next;
                size_too_big_reg  <= size_too_big_next;
                final_outcome_reg <= final_outcome_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (body_ready && body_valid)
        begin
            s1_item_reg <= body;
        end
        if (advance)
        begin
            result_item_reg <= result_item_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_item_reg;

endmodule

// ----- sv/hcbd_checker.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hcbd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   body_valid,
    input logic                   body_ready,
    input hcbd_pkg::body_item_t   body,
    input logic                   result_valid,
    input logic                   result_ready,
    input hcbd_pkg::result_item_t result
);
    import hcbd_pkg::*;

    // A stalled result transaction holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // With the result register empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> body_ready)
        else $error("input stalled with empty result register");

    // Payload bytes are only passed while the body is not yet complete.
    a_data_not_complete: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.data_valid |-> result.outcome != OUT_COMPLETE)
        else $error("payload byte reported with complete outcome");

    // Non-payload results carry a zero data byte.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.data_valid |-> result.data_byte == 8'd0)
        else $error("data byte set without data_valid");

    // No result is offered right after reset releases.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .body_valid   (body_valid),
    .body_ready   (body_ready),
    .body         (body),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
